@@ src/mpu_pkg.sv @@
`timescale 1ns / 1ps
package mpu_pkg;

  localparam int unsigned NUM_CHAN  = 4;
  localparam int unsigned PROD_W    = 40;
  localparam int unsigned DIV_STAGES = 4;

  typedef enum logic [2:0] {
    REG_RED   = 3'd0,
    REG_GREEN = 3'd1,
    REG_BLUE  = 3'd2,
    REG_ALPHA = 3'd3
  } reg_idx_t;

  localparam logic [31:0] RED_RST   = 32'h0000_00FF;
  localparam logic [31:0] GREEN_RST = 32'h0000_FF00;
  localparam logic [31:0] BLUE_RST  = 32'h00FF_0000;
  localparam logic [31:0] ALPHA_RST = 32'h0000_0000;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        last_pixel;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       end_of_run;
  } out_word_t;

  // position of lowest set bit, by OR-reducing the isolated bit
  function automatic logic [4:0] low_pos(input logic [31:0] m);
    logic [31:0] iso;
    logic [4:0]  p;
    iso = m & (~m + 32'd1);
    for (int b = 0; b < 5; b++) begin
      p[b] = 1'b0;
      for (int i = 0; i < 32; i++) begin
        if (((i >> b) & 1) == 1) p[b] = p[b] | iso[i];
      end
    end
    return p;
  endfunction

endpackage

@@ src/mpu_lane.sv @@
`timescale 1ns / 1ps
module mpu_lane import mpu_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] pix,
  input  logic [4:0]  shift,
  input  logic [31:0] fm,
  output logic [7:0]  quot
);

  logic [31:0]       field;
  logic [PROD_W-1:0] rem_r [DIV_STAGES+1];
  logic [7:0]        q_r   [DIV_STAGES+1];
  logic [PROD_W-1:0] rem_nxt [DIV_STAGES];
  logic [7:0]        q_nxt   [DIV_STAGES];

  assign field = (pix >> shift) & fm;

  // field*255 = (field << 8) - field
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {field, 8'd0} - {8'd0, field};
      q_r[0]   <= 8'd0;
    end
  end

  // restoring division, two quotient bits per stage, msb first
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    always_comb begin
      logic [PROD_W-1:0] r;
      logic [PROD_W-1:0] d;
      logic [7:0]        q;
      r = rem_r[s];
      q = q_r[s];
      for (int j = 0; j < 2; j++) begin
        d = {8'd0, fm} << (7 - 2 * s - j);
        if (r >= d) begin
          r = r - d;
          q[7 - 2 * s - j] = 1'b1;
        end
      end
      rem_nxt[s] = r;
      q_nxt[s]   = q;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= rem_nxt[s];
        q_r[s+1]   <= q_nxt[s];
      end
    end
  end

  assign quot = q_r[DIV_STAGES];

endmodule

@@ src/masked_pixel_unpack_rgba8_core.sv @@
`timescale 1ns / 1ps
// channel | handshake             | word
// in      | in_valid / in_ready   | in_data  (in_word_t)
// out     | out_valid / out_ready | out_data (out_word_t)
// cfg     | cfg_wr_en             | cfg_idx, cfg_wdata
//
// One word per cycle unless out_ready stalls; the pipe is input reg,
// field*255, four restoring-divide stages of two quotient bits each.
// Reset clears valid bits and loads the default channel masks.
// A stall at out_ready freezes the whole pipe; nothing is dropped.
// Mask-derived shift/field mask follow mask_r through a register.
module masked_pixel_unpack_rgba8_core import mpu_pkg::*; #(
  parameter int unsigned PIXEL_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_wr_en,
  input  logic [2:0] cfg_idx,
  input  logic [31:0] cfg_wdata
);

  localparam logic [31:0] PIX_MASK = 32'((64'd1 << PIXEL_WIDTH) - 64'd1);
  localparam int unsigned DEPTH = DIV_STAGES + 2;

  logic [31:0] mask_r  [NUM_CHAN];
  logic [4:0]  shift_r [NUM_CHAN];
  logic [31:0] fm_r    [NUM_CHAN];
  logic        zero_r  [NUM_CHAN];

  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] last_r;
  logic [31:0]      pix_r;
  logic             adv;
  logic [7:0]       quot [NUM_CHAN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r[0] <= RED_RST;
      mask_r[1] <= GREEN_RST;
      mask_r[2] <= BLUE_RST;
      mask_r[3] <= ALPHA_RST;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_idx))
        REG_RED:   mask_r[0] <= cfg_wdata;
        REG_GREEN: mask_r[1] <= cfg_wdata;
        REG_BLUE:  mask_r[2] <= cfg_wdata;
        REG_ALPHA: mask_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    always_ff @(posedge clk) begin
      shift_r[c] <= low_pos(mask_r[c]);
      fm_r[c]    <= mask_r[c] >> low_pos(mask_r[c]);
      zero_r[c]  <= (mask_r[c] == 32'd0);
    end

    mpu_lane u_lane (
      .clk   (clk),
      .en    (adv),
      .pix   (pix_r),
      .shift (shift_r[c]),
      .fm    (fm_r[c]),
      .quot  (quot[c])
    );
  end

  assign adv      = !vld_r[DEPTH-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_r  <= in_data.pixel_word & PIX_MASK;
      last_r <= {last_r[DEPTH-2:0], in_data.last_pixel};
    end
  end

  assign out_valid           = vld_r[DEPTH-1];
  assign out_data.red_out    = zero_r[0] ? 8'd0   : quot[0];
  assign out_data.green_out  = zero_r[1] ? 8'd0   : quot[1];
  assign out_data.blue_out   = zero_r[2] ? 8'd0   : quot[2];
  assign out_data.alpha_out  = zero_r[3] ? 8'd255 : quot[3];
  assign out_data.end_of_run = last_r[DEPTH-1];

endmodule

@@ src/mpu_checker.sv @@
`timescale 1ns / 1ps
module mpu_checker import mpu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input not ready while output drains");

endmodule

bind masked_pixel_unpack_rgba8_core mpu_checker u_mpu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
